@@ src/mbhr_pkg.sv @@
// ----------------------------------------------------------------------------
// mbhr_pkg: shared types and constants for the holding register server
// Function codes, exception codes and the request/response beat structs.
// ----------------------------------------------------------------------------
package mbhr_pkg;

   localparam int REG_COUNT_DEF = 64;

   localparam logic [7:0] FC_READ_MULTI  = 8'h03;
   localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI = 8'h10;
   localparam logic [7:0] FC_EXC_FLAG    = 8'h80;

   localparam logic [1:0] EXC_NONE         = 2'd0;
   localparam logic [1:0] EXC_ILLEGAL_FUNC = 2'd1;
   localparam logic [1:0] EXC_ILLEGAL_ADDR = 2'd2;
   localparam logic [1:0] EXC_ILLEGAL_DATA = 2'd3;

   // payload byte positions
   localparam logic [7:0] PL_ADDR_HI = 8'd0;
   localparam logic [7:0] PL_ADDR_LO = 8'd1;
   localparam logic [7:0] PL_QTY_HI  = 8'd2;
   localparam logic [7:0] PL_QTY_LO  = 8'd3;
   localparam logic [7:0] PL_BCOUNT  = 8'd4;
   localparam logic [7:0] PL_DATA    = 8'd5;
   localparam logic [7:0] PL_MAX     = 8'd255;

   typedef struct packed {
      logic [7:0] req_unit;
      logic [7:0] pdu_byte;
      logic       end_of_request;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  resp_unit;
      logic [7:0]  resp_function;
      logic [1:0]  exception_code;
      logic [7:0]  read_bytes;
      logic [15:0] first_word;
      logic [15:0] second_word;
      logic        last_result;
   } rsp_item_type;

endpackage

@@ src/modbus_holding_register_server.sv @@
// ----------------------------------------------------------------------------
// modbus_holding_register_server
// Holding register server for read multiple (0x03), write single (0x06) and
// write multiple (0x10), fed one request byte per beat.
// ----------------------------------------------------------------------------
//
//  channel | ports                   | handshake
//  --------+-------------------------+-------------------------------------
//  request | start, busy, req_item   | beat taken when start && !busy
//  result  | rsp_strobe, rsp_item    | one-cycle strobe, cannot be stalled
//
// Request bytes are taken one per beat while idle. After the closing byte the
// sequencer evaluates the request; exceptions and write single answer there.
// Read multiple then does a memory read, then an emit, for each register;
// write multiple does a staged read, then a holding write, for each register.
// Reset: synchronous; holding registers read as their own index until
// written (a valid bit per entry). Staged store is not cleared.
// Results are emitted on a strobe and the receiver cannot stall them.
// ----------------------------------------------------------------------------
module modbus_holding_register_server #(
   parameter int REG_COUNT = mbhr_pkg::REG_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mbhr_pkg::req_item_type req_item,
   output logic                   rsp_strobe,
   output mbhr_pkg::rsp_item_type rsp_item
);
   import mbhr_pkg::*;

   localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int CNT_W = $clog2(REG_COUNT + 1);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_EVAL    = 6'b000010,
      ST_RD_ADDR = 6'b000100,
      ST_RD_DATA = 6'b001000,
      ST_CM_RD   = 6'b010000,
      ST_CM_WR   = 6'b100000
   } state_type;

   state_type    state_ff, state_in;
   logic         expect_ff, expect_in;
   logic [7:0]   func_ff, func_in;
   logic [7:0]   unit_ff, unit_in;
   logic [15:0]  addr_ff, addr_in;
   logic [15:0]  qty_ff, qty_in;
   logic [7:0]   bcount_ff, bcount_in;
   logic [7:0]   plcnt_ff, plcnt_in;
   logic [7:0]   hold_ff, hold_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         strobe_ff, strobe_in;

   // holding store: memory plus a valid bit per entry
   logic [15:0]      hold_mem [REG_COUNT];
   logic [REG_COUNT-1:0] hvalid_ff;
   logic [15:0]      hrd_data_ff;
   logic             hrd_val_ff;
   logic [IDX_W-1:0] hrd_idx_ff;
   logic             hw_we;
   logic [IDX_W-1:0] hw_addr;
   logic [15:0]      hw_data;
   logic [IDX_W-1:0] hr_addr;

   // staged store for write multiple
   logic [15:0]      stg_mem [REG_COUNT];
   logic [15:0]      stg_rd_ff;
   logic             stg_we;
   logic [IDX_W-1:0] stg_waddr;
   logic [IDX_W-1:0] stg_raddr;

   logic        accept;
   logic [7:0]  data_off;
   logic [6:0]  data_word;
   logic [16:0] range_end;
   logic        range_bad;
   logic        loop_last;
   logic [IDX_W-1:0] loop_addr;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   assign data_off  = plcnt_ff - PL_DATA;
   assign data_word = data_off[7:1];
   assign range_end = {1'b0, addr_ff} + {1'b0, qty_ff};
   assign range_bad = range_end > 17'(REG_COUNT);
   assign loop_last = ({{(16-CNT_W){1'b0}}, idx_ff} + 16'd1) == qty_ff;
   assign loop_addr = addr_ff[IDX_W-1:0] + idx_ff[IDX_W-1:0];

   always_comb begin
      state_in  = state_ff;
      expect_in = expect_ff;
      func_in   = func_ff;
      unit_in   = unit_ff;
      addr_in   = addr_ff;
      qty_in    = qty_ff;
      bcount_in = bcount_ff;
      plcnt_in  = plcnt_ff;
      hold_in   = hold_ff;
      idx_in    = idx_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      hw_we     = 1'b0;
      hw_addr   = loop_addr;
      hw_data   = stg_rd_ff;
      hr_addr   = loop_addr;
      stg_we    = 1'b0;
      stg_waddr = data_word[IDX_W-1:0];
      stg_raddr = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (expect_ff) begin
                  func_in   = req_item.pdu_byte;
                  unit_in   = req_item.req_unit;
                  plcnt_in  = 8'd0;
                  addr_in   = 16'd0;
                  qty_in    = 16'd0;
                  bcount_in = 8'd0;
                  expect_in = 1'b0;
               end else if (plcnt_ff != PL_MAX) begin
                  unique case (plcnt_ff)
                     PL_ADDR_HI: addr_in   = {req_item.pdu_byte, 8'd0};
                     PL_ADDR_LO: addr_in   = {addr_ff[15:8], req_item.pdu_byte};
                     PL_QTY_HI:  qty_in    = {req_item.pdu_byte, 8'd0};
                     PL_QTY_LO:  qty_in    = {qty_ff[15:8], req_item.pdu_byte};
                     PL_BCOUNT:  bcount_in = req_item.pdu_byte;
                     default: begin
                        if (!data_off[0]) begin
                           hold_in = req_item.pdu_byte;
                        end else if (7'(data_word) < 7'(REG_COUNT)) begin
                           stg_we = 1'b1;
                        end
                     end
                  endcase
                  plcnt_in = plcnt_ff + 8'd1;
               end
               if (req_item.end_of_request) begin
                  expect_in = 1'b1;
                  state_in  = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            strobe_in = 1'b1;
            rsp_in    = '{unit_ff, func_ff | FC_EXC_FLAG, EXC_NONE, 8'd0,
                          16'd0, 16'd0, 1'b1};
            state_in  = ST_IDLE;
            idx_in    = '0;
            unique case (func_ff)
               FC_READ_MULTI: begin
                  if (plcnt_ff < PL_BCOUNT) begin
                     rsp_in.exception_code = EXC_ILLEGAL_DATA;
                  end else if (qty_ff == 16'd0 || range_bad) begin
                     rsp_in.exception_code = EXC_ILLEGAL_ADDR;
                  end else begin
                     strobe_in = 1'b0;
                     state_in  = ST_RD_ADDR;
                  end
               end
               FC_WRITE_ONE: begin
                  if (plcnt_ff < PL_BCOUNT) begin
                     rsp_in.exception_code = EXC_ILLEGAL_DATA;
                  end else if (addr_ff >= 16'(REG_COUNT)) begin
                     rsp_in.exception_code = EXC_ILLEGAL_ADDR;
                  end else begin
                     hw_we   = 1'b1;
                     hw_addr = addr_ff[IDX_W-1:0];
                     hw_data = qty_ff;
                     rsp_in  = '{unit_ff, func_ff, EXC_NONE, 8'd0,
                                 addr_ff, qty_ff, 1'b1};
                  end
               end
               FC_WRITE_MULTI: begin
                  if (plcnt_ff < PL_DATA || qty_ff == 16'd0 ||
                      {9'd0, bcount_ff} != {qty_ff, 1'b0} || range_bad ||
                      {1'b0, plcnt_ff} < ({1'b0, PL_DATA} + {1'b0, bcount_ff})) begin
                     rsp_in.exception_code = EXC_ILLEGAL_DATA;
                  end else begin
                     strobe_in = 1'b0;
                     state_in  = ST_CM_RD;
                  end
               end
               default: rsp_in.exception_code = EXC_ILLEGAL_FUNC;
            endcase
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            strobe_in = 1'b1;
            rsp_in    = '{unit_ff, FC_READ_MULTI, EXC_NONE, 8'({qty_ff, 1'b0}),
                          hrd_val_ff ? hrd_data_ff : 16'(hrd_idx_ff),
                          16'd0, loop_last};
            idx_in    = idx_ff + 1'b1;
            state_in  = loop_last ? ST_IDLE : ST_RD_ADDR;
         end
         ST_CM_RD: begin
            state_in = ST_CM_WR;
         end
         ST_CM_WR: begin
            hw_we  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (loop_last) begin
               strobe_in = 1'b1;
               rsp_in    = '{unit_ff, FC_WRITE_MULTI, EXC_NONE, 8'd0,
                             addr_ff, qty_ff, 1'b1};
               state_in  = ST_IDLE;
            end else begin
               state_in  = ST_CM_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         expect_ff <= 1'b1;
         strobe_ff <= 1'b0;
         func_ff   <= 8'd0;
         unit_ff   <= 8'd0;
         addr_ff   <= 16'd0;
         qty_ff    <= 16'd0;
         bcount_ff <= 8'd0;
         plcnt_ff  <= 8'd0;
         hold_ff   <= 8'd0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         expect_ff <= expect_in;
         strobe_ff <= strobe_in;
         func_ff   <= func_in;
         unit_ff   <= unit_in;
         addr_ff   <= addr_in;
         qty_ff    <= qty_in;
         bcount_ff <= bcount_in;
         plcnt_ff  <= plcnt_in;
         hold_ff   <= hold_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // holding store, registered read
   always_ff @(posedge clock) begin
      if (hw_we) begin
         hold_mem[hw_addr] <= hw_data;
      end
      hrd_data_ff <= hold_mem[hr_addr];
      hrd_idx_ff  <= hr_addr;
      hrd_val_ff  <= hvalid_ff[hr_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hvalid_ff <= '0;
      end else if (hw_we) begin
         hvalid_ff[hw_addr] <= 1'b1;
      end
   end

   // staged store, registered read
   always_ff @(posedge clock) begin
      if (stg_we) begin
         stg_mem[stg_waddr] <= {hold_ff, req_item.pdu_byte};
      end
      stg_rd_ff <= stg_mem[stg_raddr];
   end

`ifndef SYNTHESIS
   a_end_goes_eval: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.end_of_request) |=> (state_ff == ST_EVAL))
      else $error("closing beat did not start evaluation");
   a_strobe_from_work: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> ($past(state_ff) != ST_IDLE))
      else $error("result strobe while idle");
   a_exc_flag: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && rsp_ff.exception_code != EXC_NONE) |-> rsp_ff.resp_function[7])
      else $error("exception without flag bit");
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && rsp_ff.resp_function != FC_READ_MULTI) |-> rsp_ff.last_result)
      else $error("non-read response not marked last");
`endif

endmodule
